[rtl/core/lbd_pkg.sv]
// Shared types and constants for the lux banded dimmer with ramp.
// No dependencies; imported by the top level.
package lbd_pkg;

  // Field and register widths
  localparam int unsigned LuxW   = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned BandW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Duty levels are masked to DutyBits bits, then to the 8-bit duty field
  localparam int unsigned DutyBits = 8;
  localparam logic [DutyW-1:0] DutyMask = DutyW'((64'd1 << DutyBits) - 64'd1);
  localparam logic [DutyW-1:0] LevelHighAmbient = DutyW'(77);
  localparam logic [DutyW-1:0] LevelOff = '0;

  // Default number of repeated samples before a new goal is taken
  localparam int unsigned StableReadsDefault = 3;

  // Register reset values
  localparam logic [LuxW-1:0]  DarkThrReset   = 16'd10;
  localparam logic [LuxW-1:0]  LowThrReset    = 16'd100;
  localparam logic [LuxW-1:0]  MediumThrReset = 16'd1000;
  localparam logic [LuxW-1:0]  BrightThrReset = 16'd10000;
  localparam logic [DutyW-1:0] LevelLowReset    = 8'd64;
  localparam logic [DutyW-1:0] LevelMediumReset = 8'd128;
  localparam logic [DutyW-1:0] LevelHighReset   = 8'd255;
  localparam logic [DutyW-1:0] DimStepReset     = 8'd5;

  // Band codes
  typedef enum logic [BandW-1:0] {
    BAND_DARK   = 3'd0,
    BAND_LOW    = 3'd1,
    BAND_MEDIUM = 3'd2,
    BAND_HIGH   = 3'd3,
    BAND_BRIGHT = 3'd4
  } band_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DARK_THR    = 3'd0,
    REG_LOW_THR     = 3'd1,
    REG_MEDIUM_THR  = 3'd2,
    REG_BRIGHT_THR  = 3'd3,
    REG_LEVEL_LOW   = 3'd4,
    REG_LEVEL_MED   = 3'd5,
    REG_LEVEL_HIGH  = 3'd6,
    REG_DIM_STEP    = 3'd7
  } cfg_reg_e;

endpackage

[rtl/core/lux_banded_dimmer_with_ramp.sv]
// Top level of the lux banded dimmer with ramp: band sort, repeat filter and duty ramp.
// Depends on lbd_pkg for widths, band codes and register indexes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | lux_sample_i
//  out     | output    | out_valid_o/out_stall_i | duty_level_o, band_code_o, duty_changed_o
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// A sample is loaded into the input register at its transfer and passes through the
// band compare, repeat filter and ramp clamp into the result register once that
// register is free; out_valid_o is registered along with the result. One sample per
// cycle is sustained while the output is not stalled.
// Reset clears the duty state and loads the register defaults.
// A stall on the output holds the result register; the input register then
// fills and in_stall_o rises only while both stages are occupied.
module lux_banded_dimmer_with_ramp
  import lbd_pkg::*;
#(
  parameter int unsigned STABLE_READS = StableReadsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LuxW-1:0]     lux_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DutyW-1:0]    duty_level_o,
  output logic [BandW-1:0]    band_code_o,
  output logic                duty_changed_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(STABLE_READS + 1);
  localparam logic [CntW-1:0] CntSat = CntW'(STABLE_READS);

  // Configuration registers
  logic [LuxW-1:0]  dark_thr_q, low_thr_q, medium_thr_q, bright_thr_q;
  logic [DutyW-1:0] level_low_q, level_med_q, level_high_q, dim_step_q;

  // Pipeline registers
  logic             s1_valid_q;
  logic [LuxW-1:0]  s1_lux_q;
  logic             out_valid_q;
  logic [DutyW-1:0] out_duty_q;
  band_e            out_band_q;
  logic             out_changed_q;

  // Dimmer state
  logic [DutyW-1:0] present_q, present_d;
  logic [DutyW-1:0] goal_q, goal_d;
  logic [DutyW-1:0] prev_wanted_q;
  logic             prev_valid_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             out_free;
  logic             s1_adv;
  logic             in_xfer;
  band_e            band;
  logic [DutyW-1:0] wanted;
  logic [CntW-1:0]  cnt_inc;
  logic [DutyW:0]   up_sum;
  logic [DutyW:0]   dn_diff;

  // Handshake: the result register frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Sort the sample into a band; first test that holds wins
  always_comb begin
    if (s1_lux_q >= bright_thr_q) begin
      band   = BAND_BRIGHT;
      wanted = LevelOff;
    end else if (s1_lux_q > medium_thr_q) begin
      band   = BAND_HIGH;
      wanted = LevelHighAmbient;
    end else if (s1_lux_q > low_thr_q) begin
      band   = BAND_MEDIUM;
      wanted = level_med_q;
    end else if (s1_lux_q > dark_thr_q) begin
      band   = BAND_LOW;
      wanted = level_low_q;
    end else begin
      band   = BAND_DARK;
      wanted = level_high_q;
    end
    wanted = wanted & DutyMask;
  end

  // Repeat filter: take the goal once the wanted duty has held long enough
  always_comb begin
    cnt_inc = (cnt_q < CntSat) ? cnt_q + CntW'(1) : cnt_q;
    goal_d  = goal_q;
    if (!prev_valid_q || wanted != prev_wanted_q) begin
      cnt_d = CntW'(1);
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= CntSat) begin
        goal_d = wanted;
      end
    end
  end

  // Ramp the duty toward the goal and clamp at it
  always_comb begin
    up_sum    = {1'b0, present_q} + {1'b0, dim_step_q};
    dn_diff   = {1'b0, present_q} - {1'b0, dim_step_q};
    present_d = present_q;
    if (present_q < goal_d) begin
      present_d = (up_sum > {1'b0, goal_d}) ? goal_d : up_sum[DutyW-1:0];
    end else if (present_q > goal_d) begin
      present_d = (dn_diff[DutyW] || dn_diff[DutyW-1:0] < goal_d) ? goal_d
                                                                  : dn_diff[DutyW-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_thr_q   <= DarkThrReset;
      low_thr_q    <= LowThrReset;
      medium_thr_q <= MediumThrReset;
      bright_thr_q <= BrightThrReset;
      level_low_q  <= LevelLowReset;
      level_med_q  <= LevelMediumReset;
      level_high_q <= LevelHighReset;
      dim_step_q   <= DimStepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DARK_THR:   dark_thr_q   <= cfg_data_i;
        REG_LOW_THR:    low_thr_q    <= cfg_data_i;
        REG_MEDIUM_THR: medium_thr_q <= cfg_data_i;
        REG_BRIGHT_THR: bright_thr_q <= cfg_data_i;
        REG_LEVEL_LOW:  level_low_q  <= cfg_data_i[DutyW-1:0];
        REG_LEVEL_MED:  level_med_q  <= cfg_data_i[DutyW-1:0];
        REG_LEVEL_HIGH: level_high_q <= cfg_data_i[DutyW-1:0];
        REG_DIM_STEP:   dim_step_q   <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Control state: valid flags and dimmer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      present_q     <= '0;
      goal_q        <= '0;
      prev_wanted_q <= '0;
      prev_valid_q  <= 1'b0;
      cnt_q         <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance the dimmer state as a sample enters the result register
      if (s1_adv) begin
        present_q     <= present_d;
        goal_q        <= goal_d;
        prev_wanted_q <= wanted;
        prev_valid_q  <= 1'b1;
        cnt_q         <= cnt_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_lux_q <= lux_sample_i;
    end
    if (s1_adv) begin
      out_duty_q    <= present_d;
      out_band_q    <= band;
      out_changed_q <= (present_d != present_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_level_o   = out_duty_q;
  assign band_code_o    = out_band_q;
  assign duty_changed_o = out_changed_q;

`ifndef SYNTHESIS
  // Repeat counter never passes its saturation point
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntSat)
    else $error("repeat counter above saturation");

  // Input side stalls only while a result is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with result register free");

  // Duty state moves only when a sample passes into the result register
  a_duty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(present_q) && $stable(goal_q))
    else $error("duty state moved without a sample");

  // A fresh result reports a change exactly when the duty moved
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (duty_changed_o == (present_q != $past(present_q))))
    else $error("change flag disagrees with duty");
`endif

endmodule
